[rtl/core/bmt_pkg.sv]
`default_nettype none

package bmt_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 8;

    // Fixed field and counter widths.
    localparam int COUNT_W = 10;
    localparam int DIM_W   = 11;
    localparam int THR_W   = 8;

    // Frame geometry limits and register reset values.
    localparam int DIM_MIN      = 3;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int WIDTH_RESET  = 30;
    localparam int HEIGHT_RESET = 10;
    localparam int THR_RESET    = 10;

    // A window is centered one row and one column behind the incoming pixel,
    // so the first two rows and columns of a frame give no result.
    localparam int EDGE_SKIP = 2;

    // Number of pixels in one window.
    localparam int WINDOW_PIXELS = 9;

    // Configuration port geometry.
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Result queue depth.
    localparam int FIFO_DEPTH = 8;

    // Register index, taken from paddr bits [3:2].
    typedef enum logic [1:0] {
        REG_LINE_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_THRESHOLD    = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [DIM_W-1:0] line_width;
        logic [DIM_W-1:0] frame_height;
        logic [THR_W-1:0] threshold;
    } cfg_t;

    // Position flags of one pixel, carried down the pipeline.
    typedef struct packed {
        logic emit;
        logic row_end;
        logic frame_end;
    } pos_flags_t;

    typedef struct packed {
        logic mark;
        logic row_end;
        logic frame_end;
    } result_t;

endpackage

`default_nettype wire

[rtl/core/box_mean_3x3_threshold.sv]
// 3x3 box-mean threshold detector.
//
// Pixels enter on the s_ channel (s_valid, s_ready, s_pixel) in raster order
// for a frame of line_width by frame_height. Each pixel whose 3x3 window is
// complete, that is from the third column and third row on, gives one request
// on the m_ channel: m_mark is set when the truncated window mean exceeds
// threshold, m_row_end flags the last result of a row and m_frame_end the
// last result of the frame. Border pixels give nothing.
// One pixel is taken per clock while s_ready is high. After a pixel is accepted
// the line store read, the window and the window sum are registered in turn,
// and the compare writes the result queue. The line store is a single RAM with
// one read and one write port that holds the two previous rows per column.
// When the receiver stalls, results collect in an 8-entry queue; s_ready drops
// once queued plus in-flight results fill it, and returns as results drain.
// Reset sets the registers to width 30, height 10, threshold 10, clears the
// counters, the window and the queue. The line store is not cleared; the
// first two rows of every frame give no result, so unwritten data never reaches a result.
// The user must write the APB port only while no pixel is in flight; the block itself does not enforce this.
`default_nettype none

module box_mean_3x3_threshold
    import bmt_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIXEL_BITS-1:0] s_pixel,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_mark,
    output logic                  m_row_end,
    output logic                  m_frame_end,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW      = $clog2(MAX_WIDTH);
    localparam int CLAMP_W = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
    localparam int MEM_W   = 2 * PIXEL_BITS;
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int OCC_W   = $clog2(FIFO_DEPTH + 4);

    cfg_t                  cfg;
    logic                  accept;
    logic [CLAMP_W-1:0]    width_raw;
    logic [CLAMP_W-1:0]    width_eff;
    logic [DIM_W-1:0]      height_eff;
    logic                  last_col;
    logic                  last_row;
    logic                  in_range;
    pos_flags_t            flags;

    logic [COUNT_W-1:0]    col_reg;
    logic [COUNT_W-1:0]    col_next;
    logic [COUNT_W-1:0]    row_reg;
    logic [COUNT_W-1:0]    row_next;

    logic                  p1_valid_reg;
    logic [PIXEL_BITS-1:0] p1_px_reg;
    logic [AW-1:0]         p1_addr_reg;
    logic                  p1_inrange_reg;
    pos_flags_t            p1_flags_reg;

    logic [MEM_W-1:0]      rd_data;
    logic [PIXEL_BITS-1:0] mid_raw;
    logic [PIXEL_BITS-1:0] top_px;
    logic [PIXEL_BITS-1:0] mid_px;

    logic                  res_valid;
    result_t               res;
    logic [1:0]            pend_count;
    result_t               out_data;
    logic [CNT_W-1:0]      fifo_count;
    logic [OCC_W-1:0]      occupancy;

    // Configuration registers.
    bmt_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Clamp width and height into their supported ranges.
    always_comb begin
        width_raw = CLAMP_W'(cfg.line_width);
        if (width_raw < CLAMP_W'(DIM_MIN)) begin
            width_eff = CLAMP_W'(DIM_MIN);
        end else if (width_raw > CLAMP_W'(MAX_WIDTH)) begin
            width_eff = CLAMP_W'(MAX_WIDTH);
        end else begin
            width_eff = width_raw;
        end

        if (cfg.frame_height < DIM_W'(DIM_MIN)) begin
            height_eff = DIM_W'(DIM_MIN);
        end else if (cfg.frame_height > DIM_W'(HEIGHT_LIMIT)) begin
            height_eff = DIM_W'(HEIGHT_LIMIT);
        end else begin
            height_eff = cfg.frame_height;
        end
    end

    // Position of the incoming pixel.
    assign accept   = s_valid & s_ready;
    assign last_col = (CLAMP_W'(col_reg) + CLAMP_W'(1)) >= width_eff;
    assign last_row = (DIM_W'(row_reg) + DIM_W'(1)) >= height_eff;
    assign in_range = CLAMP_W'(col_reg) < CLAMP_W'(MAX_WIDTH);

    assign flags.emit      = (col_reg >= COUNT_W'(EDGE_SKIP)) && (row_reg >= COUNT_W'(EDGE_SKIP));
    assign flags.row_end   = last_col;
    assign flags.frame_end = last_col & last_row;

    always_comb begin
        col_next = col_reg + COUNT_W'(1);
        row_next = row_reg;
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Pixel stage that waits for the line store read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= accept;
        end
        p1_px_reg      <= s_pixel;
        p1_addr_reg    <= AW'(col_reg);
        p1_inrange_reg <= in_range;
        p1_flags_reg   <= flags;
    end

    // Line store: each column holds {previous row, row before it}. The entry
    // is read when the pixel is accepted and rewritten in the following cycle. Rows
    // are at least three wide, so consecutive pixels never share an entry.
    bmt_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (MEM_W)
    ) u_line_mem (
        .aclk    (aclk),
        .rd_en   (accept & in_range),
        .rd_addr (AW'(col_reg)),
        .rd_data (rd_data),
        .wr_en   (p1_valid_reg & p1_inrange_reg),
        .wr_addr (p1_addr_reg),
        .wr_data ({p1_px_reg, mid_raw})
    );

    assign mid_raw = rd_data[MEM_W-1:PIXEL_BITS];
    assign top_px  = p1_inrange_reg ? rd_data[PIXEL_BITS-1:0] : '0;
    assign mid_px  = p1_inrange_reg ? mid_raw : '0;

    // Window, sum and compare.
    bmt_window #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .shift_en   (p1_valid_reg),
        .top_px     (top_px),
        .mid_px     (mid_px),
        .bot_px     (p1_px_reg),
        .flags_in   (p1_flags_reg),
        .threshold  (cfg.threshold),
        .res_valid  (res_valid),
        .res        (res),
        .pend_count (pend_count)
    );

    // Result queue toward the receiver.
    bmt_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .out_ready (m_ready),
        .out_valid (m_valid),
        .out_data  (out_data),
        .count     (fifo_count)
    );

    assign m_mark      = out_data.mark;
    assign m_row_end   = out_data.row_end;
    assign m_frame_end = out_data.frame_end;

    // Accept only while every result in flight is sure of a queue slot.
    assign occupancy = OCC_W'(fifo_count)
                     + OCC_W'(p1_valid_reg & p1_flags_reg.emit)
                     + OCC_W'(pend_count);
    assign s_ready   = occupancy < OCC_W'(FIFO_DEPTH);

endmodule

`default_nettype wire

[rtl/core/bmt_cfg_regs.sv]
`default_nettype none

module bmt_cfg_regs
    import bmt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [THR_W-1:0] thr_reg;
    logic             cfg_write;
    reg_idx_t         reg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign reg_sel   = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

    // Register writes on the access cycle of a write request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(WIDTH_RESET);
            height_reg <= DIM_W'(HEIGHT_RESET);
            thr_reg    <= THR_W'(THR_RESET);
        end else if (cfg_write) begin
            case (reg_sel)
                REG_LINE_WIDTH: begin
                    width_reg <= pwdata[DIM_W-1:0];
                end
                REG_FRAME_HEIGHT: begin
                    height_reg <= pwdata[DIM_W-1:0];
                end
                REG_THRESHOLD: begin
                    thr_reg <= pwdata[THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        case (reg_sel)
            REG_LINE_WIDTH:   prdata = CFG_DATA_W'(width_reg);
            REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(height_reg);
            REG_THRESHOLD:    prdata = CFG_DATA_W'(thr_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.line_width   = width_reg;
    assign cfg.frame_height = height_reg;
    assign cfg.threshold    = thr_reg;

endmodule

`default_nettype wire

[rtl/core/bmt_line_mem.sv]
`default_nettype none

module bmt_line_mem #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 16
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data
);

    logic [DATA_W-1:0] ram [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // One write port and one read port with registered read data.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= ram[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/core/bmt_window.sv]
`default_nettype none

module bmt_window
    import bmt_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  shift_en,
    input  logic [PIXEL_BITS-1:0] top_px,
    input  logic [PIXEL_BITS-1:0] mid_px,
    input  logic [PIXEL_BITS-1:0] bot_px,
    input  pos_flags_t            flags_in,
    input  logic [THR_W-1:0]      threshold,
    output logic                  res_valid,
    output result_t               res,
    output logic [1:0]            pend_count
);

    // Sum of nine pixels needs four extra bits; the limit 9 * 256 needs 12.
    localparam int SUM_W = PIXEL_BITS + 4;
    localparam int LIM_W = (SUM_W > 12) ? SUM_W : 12;

    logic [PIXEL_BITS-1:0] win_reg [WINDOW_PIXELS];
    logic                  s2_valid_reg;
    pos_flags_t            s2_flags_reg;
    logic                  s3_valid_reg;
    pos_flags_t            s3_flags_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [SUM_W-1:0]      sum_next;
    logic [LIM_W-1:0]      limit;

    // Window shift: rows top, middle, bottom; newest column on the right.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < WINDOW_PIXELS; k++) begin
                win_reg[k] <= '0;
            end
        end else if (shift_en) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[3*k]   <= win_reg[3*k+1];
                win_reg[3*k+1] <= win_reg[3*k+2];
            end
            win_reg[2] <= top_px;
            win_reg[5] <= mid_px;
            win_reg[8] <= bot_px;
        end
    end

    // Window sum over the nine taps.
    always_comb begin
        sum_next = '0;
        for (int k = 0; k < WINDOW_PIXELS; k++) begin
            sum_next = sum_next + SUM_W'(win_reg[k]);
        end
    end

    // Sum stage, registered from the window in the cycle after its update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= shift_en & flags_in.emit;
            s3_valid_reg <= s2_valid_reg;
        end
        s2_flags_reg <= flags_in;
        s3_flags_reg <= s2_flags_reg;
        sum_reg      <= sum_next;
    end

    // floor(sum / 9) > threshold is the same as sum >= 9 * (threshold + 1).
    assign limit = LIM_W'(WINDOW_PIXELS) * (LIM_W'(threshold) + LIM_W'(1));

    assign res_valid     = s3_valid_reg;
    assign res.mark      = (LIM_W'(sum_reg) >= limit);
    assign res.row_end   = s3_flags_reg.row_end;
    assign res.frame_end = s3_flags_reg.frame_end;
    assign pend_count    = {1'b0, s2_valid_reg} + {1'b0, s3_valid_reg};

endmodule

`default_nettype wire

[rtl/core/bmt_out_fifo.sv]
`default_nettype none

module bmt_out_fifo
    import bmt_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  result_t                    push_data,
    input  logic                       out_ready,
    output logic                       out_valid,
    output result_t                    out_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t          slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    assign pop       = out_valid & out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!push && pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Storage for queued results.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[rtl/core/bmt_checker.sv]
`default_nettype none

module bmt_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_mark,
    input logic m_row_end,
    input logic m_frame_end,
    input logic pready
);

    // The last result of a frame is also the last of its row.
    a_frame_end_row_end: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_end) |-> m_row_end
    ) else $error("frame end without row end");

    // A stalled result request holds its payload.
    a_result_hold: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_mark) && $stable(m_row_end)
                                   && $stable(m_frame_end))
    ) else $error("stalled result changed or dropped");

    // Reset empties the result queue.
    a_reset_empty: assert property (
        @(posedge aclk)
        !aresetn |=> !m_valid
    ) else $error("result valid after reset");

    // A result into an empty queue comes from an accepted pixel.
    a_latency: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 4)
    ) else $error("result without matching pixel");

    // The configuration port never inserts wait states.
    a_pready_high: assert property (
        @(posedge aclk) disable iff (!aresetn)
        pready
    ) else $error("pready low");

endmodule

bind box_mean_3x3_threshold bmt_checker u_bmt_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_mark      (m_mark),
    .m_row_end   (m_row_end),
    .m_frame_end (m_frame_end),
    .pready      (pready)
);

`default_nettype wire
